// ----- sv/rcti_pkg.sv -----
`default_nettype none
package rcti_pkg;

    // field widths
    localparam int W      = 24;   // every payload field
    localparam int PW     = W + 1; // right/bottom, differences, magnitudes
    localparam int EW     = W - 1; // positive extent or cut
    localparam int NUMW   = EW + PW; // cut * magnitude
    localparam int NW     = NUMW + 1; // 2*num + den
    localparam int DW     = EW + 1; // 2*den
    localparam int QW     = PW;   // rounded quotient bits
    localparam int NLANE  = 4;
    localparam int NSTEP  = QW;   // divider stages, one quotient bit each

    // texture lanes
    localparam int LANE_S1 = 0;
    localparam int LANE_T1 = 1;
    localparam int LANE_S2 = 2;
    localparam int LANE_T2 = 3;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_CLIP_LEFT   = 2'd0,
        REG_CLIP_TOP    = 2'd1,
        REG_CLIP_RIGHT  = 2'd2,
        REG_CLIP_BOTTOM = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
        logic signed [W-1:0] w;
        logic signed [W-1:0] h;
        logic signed [W-1:0] s1;
        logic signed [W-1:0] t1;
        logic signed [W-1:0] s2;
        logic signed [W-1:0] t2;
    } t_quad;

    typedef struct packed {
        logic signed [W-1:0] left;
        logic signed [W-1:0] top;
        logic signed [W-1:0] right;
        logic signed [W-1:0] bottom;
    } t_clip;

    // result fields that bypass the divider
    typedef struct packed {
        logic                  culled;
        logic                  clip_off;
        logic [W-1:0]          ox;
        logic [W-1:0]          oy;
        logic [W-1:0]          ow;
        logic [W-1:0]          oh;
        logic [NLANE-1:0][W-1:0] near;
        logic [NLANE-1:0]      neg;
    } t_side;

    typedef struct packed {
        t_side                    side;
        logic [NLANE-1:0][NUMW-1:0] num;
        logic [NLANE-1:0][EW-1:0]   ext;
    } t_mul;

    typedef struct packed {
        t_side                  side;
        logic [NLANE-1:0][PW-1:0] rem;
        logic [NLANE-1:0][QW-1:0] nlo;
        logic [NLANE-1:0][DW-1:0] d;
        logic [NLANE-1:0][QW-1:0] q;
    } t_dst;

endpackage
`default_nettype wire

// ----- sv/rcti_if.sv -----
`default_nettype none
interface rcti_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [23:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

interface rcti_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] in_x;
    logic [23:0] in_y;
    logic [23:0] in_w;
    logic [23:0] in_h;
    logic [23:0] in_s1;
    logic [23:0] in_t1;
    logic [23:0] in_s2;
    logic [23:0] in_t2;
    modport source (output valid, output in_x, output in_y, output in_w, output in_h,
                    output in_s1, output in_t1, output in_s2, output in_t2, input ready);
    modport sink (input valid, input in_x, input in_y, input in_w, input in_h,
                  input in_s1, input in_t1, input in_s2, input in_t2, output ready);
endinterface

interface rcti_out_if;
    logic        valid;
    logic        ready;
    logic        culled;
    logic        clip_off;
    logic [23:0] out_x;
    logic [23:0] out_y;
    logic [23:0] out_w;
    logic [23:0] out_h;
    logic [23:0] out_s1;
    logic [23:0] out_t1;
    logic [23:0] out_s2;
    logic [23:0] out_t2;
    modport source (output valid, output culled, output clip_off, output out_x,
                    output out_y, output out_w, output out_h, output out_s1,
                    output out_t1, output out_s2, output out_t2, input ready);
    modport sink (input valid, input culled, input clip_off, input out_x,
                  input out_y, input out_w, input out_h, input out_s1,
                  input out_t1, input out_s2, input out_t2, output ready);
endinterface
`default_nettype wire

// ----- sv/rcti_setup.sv -----
`default_nettype none
module rcti_setup import rcti_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_en,
    input  wire   i_valid,
    input  t_quad i_quad,
    input  t_clip i_clip,
    output logic  o_valid,
    output t_mul  o_mul
);

    logic r_v1, r_v2, r_v3, r_v4;
    t_quad r_q1, r_q2;
    logic signed [PW-1:0] r_right, r_bottom, r_ds, r_dt;
    t_side r_side3;
    logic [NLANE-1:0][EW-1:0] r_cut, r_ext;
    logic [NLANE-1:0][PW-1:0] r_mag;
    t_mul r_mul;

    logic signed [PW-1:0] n_right, n_bottom, n_ds, n_dt;
    t_side n_side3;
    logic [NLANE-1:0][EW-1:0] n_cut, n_ext;
    logic [NLANE-1:0][PW-1:0] n_mag;
    t_mul n_mul;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // stage 2: far edges and texture deltas
    always_comb begin
        n_right  = PW'(r_q1.x) + PW'(r_q1.w);
        n_bottom = PW'(r_q1.y) + PW'(r_q1.h);
        n_ds     = PW'(r_q1.s2) - PW'(r_q1.s1);
        n_dt     = PW'(r_q1.t2) - PW'(r_q1.t1);
    end

    // stage 3: classify, clipped geometry, lane operands
    always_comb begin
        logic signed [PW-1:0] cl, ct, cr, cb, lf, tp, nx, ny, nr, nb, ww, hh;
        logic off, cul, lc, rc, tc, bc;
        cl = PW'(i_clip.left);
        ct = PW'(i_clip.top);
        cr = PW'(i_clip.right);
        cb = PW'(i_clip.bottom);
        lf = PW'(r_q2.x);
        tp = PW'(r_q2.y);
        off = (cr <= cl) || (cb <= ct);
        cul = !off && ((r_right <= cl) || (lf >= cr) || (r_bottom <= ct) || (tp >= cb));
        lc = !off && !cul && (lf < cl);
        rc = !off && !cul && (r_right > cr);
        tc = !off && !cul && (tp < ct);
        bc = !off && !cul && (r_bottom > cb);
        nx = lc ? cl : lf;
        nr = rc ? cr : r_right;
        ny = tc ? ct : tp;
        nb = bc ? cb : r_bottom;
        ww = nr - nx;
        hh = nb - ny;
        n_side3.culled   = cul;
        n_side3.clip_off = off;
        n_side3.ox = cul ? '0 : nx[W-1:0];
        n_side3.oy = cul ? '0 : ny[W-1:0];
        n_side3.ow = cul ? '0 : (off ? r_q2.w : ww[W-1:0]);
        n_side3.oh = cul ? '0 : (off ? r_q2.h : hh[W-1:0]);
        n_side3.near[LANE_S1] = cul ? '0 : r_q2.s1;
        n_side3.near[LANE_T1] = cul ? '0 : r_q2.t1;
        n_side3.near[LANE_S2] = cul ? '0 : r_q2.s2;
        n_side3.near[LANE_T2] = cul ? '0 : r_q2.t2;
        n_side3.neg[LANE_S1] = r_ds[PW-1];
        n_side3.neg[LANE_S2] = !r_ds[PW-1] && (r_ds != '0);
        n_side3.neg[LANE_T1] = r_dt[PW-1];
        n_side3.neg[LANE_T2] = !r_dt[PW-1] && (r_dt != '0);
        n_mag[LANE_S1] = r_ds[PW-1] ? PW'(-r_ds) : PW'(r_ds);
        n_mag[LANE_S2] = n_mag[LANE_S1];
        n_mag[LANE_T1] = r_dt[PW-1] ? PW'(-r_dt) : PW'(r_dt);
        n_mag[LANE_T2] = n_mag[LANE_T1];
        // idle lanes divide zero by one so the near value passes
        n_cut[LANE_S1] = lc ? EW'(cl - lf) : '0;
        n_cut[LANE_S2] = rc ? EW'(r_right - cr) : '0;
        n_cut[LANE_T1] = tc ? EW'(ct - tp) : '0;
        n_cut[LANE_T2] = bc ? EW'(r_bottom - cb) : '0;
        n_ext[LANE_S1] = lc ? r_q2.w[EW-1:0] : EW'(1);
        n_ext[LANE_S2] = rc ? r_q2.w[EW-1:0] : EW'(1);
        n_ext[LANE_T1] = tc ? r_q2.h[EW-1:0] : EW'(1);
        n_ext[LANE_T2] = bc ? r_q2.h[EW-1:0] : EW'(1);
    end

    // stage 4: products
    always_comb begin
        n_mul.side = r_side3;
        for (int l = 0; l < NLANE; l++) begin
            n_mul.num[l] = NUMW'(r_cut[l]) * NUMW'(r_mag[l]);
            n_mul.ext[l] = r_ext[l];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q1     <= i_quad;
            r_q2     <= r_q1;
            r_right  <= n_right;
            r_bottom <= n_bottom;
            r_ds     <= n_ds;
            r_dt     <= n_dt;
            r_side3  <= n_side3;
            r_cut    <= n_cut;
            r_ext    <= n_ext;
            r_mag    <= n_mag;
            r_mul    <= n_mul;
        end
    end

    assign o_valid = r_v4;
    assign o_mul   = r_mul;

endmodule
`default_nettype wire

// ----- sv/rcti_div.sv -----
`default_nettype none
module rcti_div import rcti_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_en,
    input  wire   i_valid,
    input  t_mul  i_mul,
    output logic  o_valid,
    output t_side o_side,
    output logic [NLANE-1:0][QW-1:0] o_q
);

    // one restoring step per stage on every lane
    function automatic t_dst f_step(t_dst a);
        t_dst b;
        logic [PW:0] t;
        logic [PW:0] dd;
        logic bit_q;
        b = a;
        for (int l = 0; l < NLANE; l++) begin
            t  = {a.rem[l], a.nlo[l][QW-1]};
            dd = (PW+1)'(a.d[l]);
            bit_q = (t >= dd);
            b.rem[l] = bit_q ? PW'(t - dd) : t[PW-1:0];
            b.q[l]   = {a.q[l][QW-2:0], bit_q};
            b.nlo[l] = {a.nlo[l][QW-2:0], 1'b0};
        end
        return b;
    endfunction

    t_dst r_st [0:NSTEP];
    logic r_v  [0:NSTEP];
    t_dst n_st0;

    // rounding: floor((2*num + den) / (2*den))
    always_comb begin
        logic [NW-1:0] nn;
        n_st0.side = i_mul.side;
        for (int l = 0; l < NLANE; l++) begin
            nn = {i_mul.num[l], 1'b0} + NW'(i_mul.ext[l]);
            n_st0.rem[l] = PW'(nn[NW-1:QW]);
            n_st0.nlo[l] = nn[QW-1:0];
            n_st0.d[l]   = {i_mul.ext[l], 1'b0};
            n_st0.q[l]   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= n_st0;
        end
    end

    for (genvar k = 1; k <= NSTEP; k++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= f_step(r_st[k-1]);
            end
        end
    end

    assign o_valid = r_v[NSTEP];
    assign o_side  = r_st[NSTEP].side;
    assign o_q     = r_st[NSTEP].q;

endmodule
`default_nettype wire

// ----- sv/rect_clip_with_texcoord_interp.sv -----
`default_nettype none
// Pipeline from accepted item to result valid: 4 setup stages, 26 divider
// stages, 1 output register. Throughput: one item per cycle while the output
// slot is free or being taken; the rounded interpolation is a 25-stage
// restoring divider, one quotient bit per stage, four lanes side by side.
// Reset (synchronous, active low) empties the pipeline and clears the clip
// rectangle to zero, which passes quads through unchanged.
module rect_clip_with_texcoord_interp import rcti_pkg::*; (
    input wire           i_clk,
    input wire           i_rst_n,
    rcti_cfg_if.sink     i_cfg,
    rcti_in_if.sink      i_in,
    rcti_out_if.source   o_out
);

    t_clip r_clip;
    logic  en;
    t_quad quad;
    logic  setup_valid, div_valid;
    t_mul  setup_mul;
    t_side div_side;
    logic [NLANE-1:0][QW-1:0] div_q;
    logic  r_out_valid;
    t_side r_out_side;
    logic [NLANE-1:0][W-1:0] r_out_tc;
    logic [NLANE-1:0][W-1:0] n_out_tc;

    // configuration registers
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip <= '0;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_CLIP_LEFT:   r_clip.left   <= i_cfg.data;
                REG_CLIP_TOP:    r_clip.top    <= i_cfg.data;
                REG_CLIP_RIGHT:  r_clip.right  <= i_cfg.data;
                REG_CLIP_BOTTOM: r_clip.bottom <= i_cfg.data;
                default: r_clip <= r_clip;
            endcase
        end
    end

    // whole pipeline advances when the output slot is free or being taken
    assign en         = !r_out_valid || o_out.ready;
    assign i_in.ready = en;

    assign quad.x  = i_in.in_x;
    assign quad.y  = i_in.in_y;
    assign quad.w  = i_in.in_w;
    assign quad.h  = i_in.in_h;
    assign quad.s1 = i_in.in_s1;
    assign quad.t1 = i_in.in_t1;
    assign quad.s2 = i_in.in_s2;
    assign quad.t2 = i_in.in_t2;

    rcti_setup u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_quad  (quad),
        .i_clip  (r_clip),
        .o_valid (setup_valid),
        .o_mul   (setup_mul)
    );

    rcti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (setup_valid),
        .i_mul   (setup_mul),
        .o_valid (div_valid),
        .o_side  (div_side),
        .o_q     (div_q)
    );

    // apply the signed step to the near coordinate
    always_comb begin
        logic signed [PW-1:0] nv;
        for (int l = 0; l < NLANE; l++) begin
            nv = PW'($signed(div_side.near[l]));
            n_out_tc[l] = div_side.neg[l] ? W'(nv - $signed(div_q[l]))
                                          : W'(nv + $signed(div_q[l]));
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_side <= div_side;
            r_out_tc   <= n_out_tc;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.culled   = r_out_side.culled;
    assign o_out.clip_off = r_out_side.clip_off;
    assign o_out.out_x    = r_out_side.ox;
    assign o_out.out_y    = r_out_side.oy;
    assign o_out.out_w    = r_out_side.ow;
    assign o_out.out_h    = r_out_side.oh;
    assign o_out.out_s1   = r_out_tc[LANE_S1];
    assign o_out.out_t1   = r_out_tc[LANE_T1];
    assign o_out.out_s2   = r_out_tc[LANE_S2];
    assign o_out.out_t2   = r_out_tc[LANE_T2];

endmodule
`default_nettype wire

// ----- verif/rcti_tb_if.sv -----
`timescale 1ns / 100ps
// The channel interfaces are compiled from the RTL file list; this file holds the
// testbench-side item records only.
package rcti_tb_pkg;
    import rcti_pkg::*;

    typedef struct {
        logic                culled;
        logic                clip_off;
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
        logic signed [W-1:0] w;
        logic signed [W-1:0] h;
        logic signed [W-1:0] s1;
        logic signed [W-1:0] t1;
        logic signed [W-1:0] s2;
        logic signed [W-1:0] t2;
    } t_clip_res;
endpackage

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
module testbench;
    import rcti_pkg::*;
    import rcti_tb_pkg::*;

    localparam int LATENCY = 31;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rcti_cfg_if cfg_ch();
    rcti_in_if in_ch();
    rcti_out_if out_ch();

    rect_clip_with_texcoord_interp dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg(cfg_ch.sink), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    always #10 i_clk = ~i_clk;

    // predictor copy of the clip rectangle
    longint clip_l, clip_t, clip_r, clip_b;

    t_quad     quad_q[$];
    t_clip_res expected_q[$];
    int        n_err = 0;
    int        n_quads = 0;
    int        n_culled = 0;
    int        n_off = 0;
    int        n_cut = 0;
    bit        no_idle = 0;
    bit        hold_send = 0;
    int        send_gap = 0;
    int        sink_gap = 0;

    // near + cut*(far-near)/extent, rounded half away from zero
    function automatic longint lerp_edge(longint nc, longint fc, longint cut, longint ext);
        longint d;
        longint mag;
        longint q;
        d = fc - nc;
        mag = (d < 0) ? -d : d;
        if (ext == 0) return nc;
        q = (2 * cut * mag + ext) / (2 * ext);
        return (d < 0) ? nc - q : nc + q;
    endfunction

    function automatic t_clip_res clip_quad(t_quad qd);
        t_clip_res r;
        longint x, y, w, h, s1, t1, s2, t2, rgt, bot;
        longint ox, oy, ow, oh, os1, ot1, os2, ot2;
        x = 64'(qd.x); y = 64'(qd.y); w = 64'(qd.w); h = 64'(qd.h);
        s1 = 64'(qd.s1); t1 = 64'(qd.t1); s2 = 64'(qd.s2); t2 = 64'(qd.t2);
        rgt = x + w; bot = y + h;
        ox = x; oy = y; ow = w; oh = h;
        os1 = s1; ot1 = t1; os2 = s2; ot2 = t2;
        r.culled = 0; r.clip_off = 0;
        if (clip_r <= clip_l || clip_b <= clip_t) begin
            r.clip_off = 1;
        end else if (rgt <= clip_l || x >= clip_r || bot <= clip_t || y >= clip_b) begin
            r.culled = 1;
            ox = 0; oy = 0; ow = 0; oh = 0; os1 = 0; ot1 = 0; os2 = 0; ot2 = 0;
        end else begin
            if (x < clip_l) begin
                os1 = lerp_edge(s1, s2, clip_l - x, rgt - x);
                ox = clip_l;
                ow = rgt - clip_l;
            end
            if (rgt > clip_r) begin
                os2 = lerp_edge(s2, s1, rgt - clip_r, rgt - x);
                ow = clip_r - ox;
            end
            if (y < clip_t) begin
                ot1 = lerp_edge(t1, t2, clip_t - y, bot - y);
                oy = clip_t;
                oh = bot - clip_t;
            end
            if (bot > clip_b) begin
                ot2 = lerp_edge(t2, t1, bot - clip_b, bot - y);
                oh = clip_b - oy;
            end
        end
        r.x = ox[W-1:0]; r.y = oy[W-1:0]; r.w = ow[W-1:0]; r.h = oh[W-1:0];
        r.s1 = os1[W-1:0]; r.t1 = ot1[W-1:0]; r.s2 = os2[W-1:0]; r.t2 = ot2[W-1:0];
        return r;
    endfunction

    // quad driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) send_gap = (!no_idle && $urandom_range(0, 9) == 0)
                ? $urandom_range(1, 19) : 0;
            if (send_gap > 0) begin
                send_gap--;
                in_ch.valid <= 1'b0;
            end else if (quad_q.size() > 0 && !hold_send) begin
                in_ch.valid <= 1'b1;
                in_ch.in_x <= quad_q[0].x;   in_ch.in_y <= quad_q[0].y;
                in_ch.in_w <= quad_q[0].w;   in_ch.in_h <= quad_q[0].h;
                in_ch.in_s1 <= quad_q[0].s1; in_ch.in_t1 <= quad_q[0].t1;
                in_ch.in_s2 <= quad_q[0].s2; in_ch.in_t2 <= quad_q[0].t2;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // accept side: predict on each accepted quad
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            t_quad qd;
            qd = quad_q.pop_front();
            expected_q.push_back(clip_quad(qd));
            n_quads++;
        end
    end

    // result sink ready with random stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            out_ch.ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 11) == 0) begin
            sink_gap = $urandom_range(0, 18);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            t_clip_res e;
            t_clip_res a;
            a.culled = out_ch.culled; a.clip_off = out_ch.clip_off;
            a.x = out_ch.out_x; a.y = out_ch.out_y; a.w = out_ch.out_w; a.h = out_ch.out_h;
            a.s1 = out_ch.out_s1; a.t1 = out_ch.out_t1;
            a.s2 = out_ch.out_s2; a.t2 = out_ch.out_t2;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result item", $realtime);
                n_err++;
            end else begin
                e = expected_q.pop_front();
                if (e.culled) n_culled++;
                else if (e.clip_off) n_off++;
                else n_cut++;
                if (a.culled !== e.culled || a.clip_off !== e.clip_off) begin
                    $display("%0t: flags exp culled=%0b off=%0b got culled=%0b off=%0b",
                             $realtime, e.culled, e.clip_off, a.culled, a.clip_off);
                    n_err++;
                end
                if ({a.x, a.y, a.w, a.h} !== {e.x, e.y, e.w, e.h}) begin
                    $display("%0t: geometry exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                             $realtime, e.x, e.y, e.w, e.h, a.x, a.y, a.w, a.h);
                    n_err++;
                end
                if ({a.s1, a.t1, a.s2, a.t2} !== {e.s1, e.t1, e.s2, e.t2}) begin
                    $display("%0t: texcoord exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                             $realtime, e.s1, e.t1, e.s2, e.t2, a.s1, a.t1, a.s2, a.t2);
                    n_err++;
                end
            end
        end
    end

    task automatic write_reg(t_reg_idx idx, logic signed [W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_CLIP_LEFT:   clip_l = 64'(val);
            REG_CLIP_TOP:    clip_t = 64'(val);
            REG_CLIP_RIGHT:  clip_r = 64'(val);
            default:         clip_b = 64'(val);
        endcase
    endtask

    task automatic set_clip(int l, int t, int r, int b);
        write_reg(REG_CLIP_LEFT, W'(l));
        write_reg(REG_CLIP_TOP, W'(t));
        write_reg(REG_CLIP_RIGHT, W'(r));
        write_reg(REG_CLIP_BOTTOM, W'(b));
    endtask

    task automatic drain();
        while (quad_q.size() > 0 || expected_q.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic push_quad(int x, int y, int w, int h, int s1, int t1, int s2, int t2);
        t_quad qd;
        qd.x = W'(x); qd.y = W'(y); qd.w = W'(w); qd.h = W'(h);
        qd.s1 = W'(s1); qd.t1 = W'(t1); qd.s2 = W'(s2); qd.t2 = W'(t2);
        quad_q.push_back(qd);
    endtask

    function automatic int rnd24();
        return $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8;
    endfunction

    // mostly quads near the clip window, some anywhere
    task automatic push_random(int n, int span);
        int cx, cy;
        repeat (n) begin
            if ($urandom_range(0, 4) == 0) begin
                push_quad(rnd24(), rnd24(), rnd24(), rnd24(), rnd24(), rnd24(), rnd24(), rnd24());
            end else begin
                cx = int'((clip_l + clip_r) / 2);
                cy = int'((clip_t + clip_b) / 2);
                push_quad(cx + $signed($urandom_range(0, 2 * span)) - span,
                          cy + $signed($urandom_range(0, 2 * span)) - span,
                          $urandom_range(0, span) - span / 16,
                          $urandom_range(0, span) - span / 16,
                          rnd24(), rnd24(), rnd24(), rnd24());
            end
        end
    endtask

    // stimulus
    initial begin
        cfg_ch.valid = 1'b0; cfg_ch.index = REG_CLIP_LEFT; cfg_ch.data = '0;
        in_ch.valid = 1'b0;
        in_ch.in_x = '0; in_ch.in_y = '0; in_ch.in_w = '0; in_ch.in_h = '0;
        in_ch.in_s1 = '0; in_ch.in_t1 = '0; in_ch.in_s2 = '0; in_ch.in_t2 = '0;
        out_ch.ready = 1'b0;
        clip_l = 0; clip_t = 0; clip_r = 0; clip_b = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset rectangle is empty: pass-through, extremes
        push_quad(24'h7FFFFF, -24'sd8388608, 24'h7FFFFF, -24'sd8388608,
                  24'h7FFFFF, -24'sd8388608, 24'h7FFFFF, -24'sd8388608);
        push_quad(-24'sd1, 0, 1, -24'sd1, 0, -24'sd1, 1, 0);
        drain();

        // moderate window: inside, culled each side, crossing each edge, ties
        set_clip(1000, 2000, 5000, 6000);
        push_quad(1500, 2500, 100, 100, 10, 20, 30, 40);
        push_quad(0, 2500, 1000, 100, 1, 2, 3, 4);
        push_quad(5000, 2500, 100, 100, 1, 2, 3, 4);
        push_quad(1500, 0, 100, 2000, 1, 2, 3, 4);
        push_quad(1500, 6000, 100, 100, 1, 2, 3, 4);
        push_quad(0, 0, 8000, 8000, 0, 0, 65536, -65536);
        push_quad(500, 1500, 1000, 1000, 3, 3, 0, 0);
        push_quad(4500, 5500, 1000, 1000, -24'sd8388608, 24'h7FFFFF, 24'h7FFFFF, -24'sd8388608);
        push_quad(2000, 3000, -24'sd500, 0, 1, 2, 3, 4);
        push_quad(-24'sd8388608, -24'sd8388608, 24'h7FFFFF, 24'h7FFFFF, 7, -7, -7, 7);
        push_quad(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1, 2, 3, 4);
        drain();

        // empty by top/bottom only
        set_clip(-24'sd100, 50, 100, 50);
        push_quad(0, 0, 10, 10, 1, 2, 3, 4);
        drain();

        // extreme full-range window
        set_clip(-24'sd8388608, -24'sd8388608, 24'h7FFFFF, 24'h7FFFFF);
        push_quad(-24'sd8388608, 0, 24'h7FFFFF, 24'h7FFFFF, 5, 6, -24'sd8388608, 24'h7FFFFF);
        push_random(150, 24'h7FFFFF);
        drain();

        // sender holds midway until all results are back
        set_clip(-24'sd3000, -24'sd4000, 3000, 4000);
        push_random(200, 6000);
        while (quad_q.size() > 100) @(posedge i_clk);
        hold_send = 1;
        while (expected_q.size() > 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        hold_send = 0;
        drain();
        push_random(200, 6000);
        drain();

        // narrow window and a random one
        set_clip(10, 10, 11, 12);
        push_random(150, 64);
        drain();
        set_clip(rnd24() / 2, rnd24() / 2, 24'h7FFFFF, 24'h7FFFFF);
        push_random(100, 24'h3FFFFF);
        drain();

        // no idling at the end
        set_clip(0, 0, 256, 256);
        no_idle = 1;
        push_random(150, 512);
        drain();

        $display("%0d quads: %0d clipped/inside, %0d culled, %0d pass-through over 8 windows",
                 n_quads, n_cut, n_culled, n_off);
        if (n_err == 0)
            $display("rect_clip_with_texcoord_interp verification clean");
        else
            $display("rect_clip_with_texcoord_interp verification failed");
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("rect_clip_with_texcoord_interp verification failed");
        $finish;
    end
endmodule
